// File: hdl/tsr_pkg.sv
// Shared types and constants for the tube statistic reducer.
// No dependencies; every other file of the block imports this package.
package tsr_pkg;

    // Fixed port widths.
    localparam int FIELD_W  = 24;
    localparam int RESULT_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int STAT_W   = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STATISTIC    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_MISSING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISSING_CODE = 2'd2;

    // Statistic codes.
    localparam logic [STAT_W-1:0] STAT_MEAN   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MAX    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MIN    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_STDDEV = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SUM    = 3'd4;

    // Reset value of the missing code register.
    localparam logic [FIELD_W-1:0] MISSING_RESET = 24'h800000;

    // Configuration as seen by the front and back ends.
    typedef struct packed {
        logic [STAT_W-1:0]  statistic;
        logic               drop_missing;
        logic [FIELD_W-1:0] missing_code;
    } t_cfg;

    // Per-tube status carried with each finished tube.
    typedef struct packed {
        logic length_overflow;
        logic saw_missing;
    } t_tube_flags;

endpackage

// File: hdl/tsr_front.sv
// Front end of the tube statistic reducer: accumulates count, sum, sum of
// squares, minimum and maximum per tube. Depends on tsr_pkg.
module tsr_front
    import tsr_pkg::*;
#(
    parameter int MAX_TUBE_LENGTH = 1024,
    parameter int SAMPLE_BITS     = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_accept,
    input  logic [FIELD_W-1:0]   i_sample,
    input  logic                 i_last_in_tube,
    output logic                 o_rec_push,
    output logic [2*($clog2(MAX_TUBE_LENGTH+1))+(SAMPLE_BITS+$clog2(MAX_TUBE_LENGTH+1))
                  +(2*SAMPLE_BITS-2+$clog2(MAX_TUBE_LENGTH+1))-$clog2(MAX_TUBE_LENGTH+1)
                  +2*SAMPLE_BITS+2-1:0] o_rec
);

    localparam int CW   = $clog2(MAX_TUBE_LENGTH + 1);
    localparam int SUMW = SAMPLE_BITS + CW;
    localparam int SQSW = 2 * SAMPLE_BITS - 2 + CW;
    localparam int S    = SAMPLE_BITS;

    // Tube accumulators.
    logic [CW-1:0]          r_len;
    logic [CW-1:0]          r_cnt;
    logic signed [SUMW-1:0] r_sum;
    logic [SQSW-1:0]        r_sq;
    logic signed [S-1:0]    r_min;
    logic signed [S-1:0]    r_max;
    t_tube_flags            r_flags;

    logic [CW-1:0]          n_len;
    logic [CW-1:0]          n_cnt;
    logic signed [SUMW-1:0] n_sum;
    logic [SQSW-1:0]        n_sq;
    logic signed [S-1:0]    n_min;
    logic signed [S-1:0]    n_max;
    t_tube_flags            n_flags;

    logic signed [S-1:0]    w_x;
    logic signed [2*S-1:0]  w_sq;
    logic                   w_is_missing;
    logic                   w_len_full;
    logic signed [S-1:0]    w_min_reset;
    logic signed [S-1:0]    w_max_reset;

    assign w_x          = i_sample[S-1:0];
    assign w_sq         = w_x * w_x;
    assign w_is_missing = (i_sample[S-1:0] == i_cfg.missing_code[S-1:0]);
    assign w_len_full   = (r_len == CW'(MAX_TUBE_LENGTH));
    assign w_max_reset  = {1'b1, {(S-1){1'b0}}};
    assign w_min_reset  = ~w_max_reset;

    // Fold the incoming sample into the tube state.
    always_comb begin
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_sq    = r_sq;
        n_min   = r_min;
        n_max   = r_max;
        n_flags = r_flags;
        if (w_len_full) begin
            n_flags.length_overflow = 1'b1;
        end else begin
            n_len = r_len + 1'b1;
            if (w_is_missing) begin
                n_flags.saw_missing = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
                n_sum = r_sum + SUMW'(w_x);
                n_sq  = r_sq + SQSW'(w_sq[2*S-2:0]);
                if (w_x < r_min) begin
                    n_min = w_x;
                end
                if (w_x > r_max) begin
                    n_max = w_x;
                end
            end
        end
    end

    // A finished tube is handed to the queue on its last sample.
    assign o_rec_push = i_accept && i_last_in_tube;
    assign o_rec      = {n_cnt, n_sum, n_sq, n_min, n_max, n_flags};

    // Accumulator registers; cleared after the last sample of a tube.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_in_tube)) begin
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_min   <= w_min_reset;
            r_max   <= w_max_reset;
            r_flags <= '0;
        end else if (i_accept) begin
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_sq    <= n_sq;
            r_min   <= n_min;
            r_max   <= n_max;
            r_flags <= n_flags;
        end
    end

endmodule

// File: hdl/tsr_queue.sv
// Two-entry queue of finished tube records between front and back ends.
// Depends on tsr_pkg only by convention; holds plain data words.
module tsr_queue
    import tsr_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr <= ~r_wr;
            end
            if (w_do_pop) begin
                r_rd <= ~r_rd;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: hdl/tsr_back.sv
// Back end of the tube statistic reducer: turns a tube record into the chosen
// statistic with bit-serial multiply, divide and square root. Depends on tsr_pkg.
module tsr_back
    import tsr_pkg::*;
#(
    parameter int MAX_TUBE_LENGTH = 1024,
    parameter int SAMPLE_BITS     = 24,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_rec_valid,
    input  logic [2*($clog2(MAX_TUBE_LENGTH+1))+(SAMPLE_BITS+$clog2(MAX_TUBE_LENGTH+1))
                  +(2*SAMPLE_BITS-2+$clog2(MAX_TUBE_LENGTH+1))-$clog2(MAX_TUBE_LENGTH+1)
                  +2*SAMPLE_BITS+2-1:0] i_rec,
    output logic                 o_rec_pop,
    output logic                 o_valid,
    input  logic                 i_pop,
    output logic [RESULT_W-1:0]  o_value,
    output logic                 o_na
);

    localparam int S     = SAMPLE_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int CW    = $clog2(MAX_TUBE_LENGTH + 1);
    localparam int SUMW  = S + CW;
    localparam int SQSW  = 2 * S - 2 + CW;
    localparam int DW    = 2 * S - 2 + 2 * CW;
    localparam int DVW   = 2 * CW;
    localparam int NRAW  = DW + 2 * F + 2;
    localparam int NW    = NRAW + (NRAW % 2);
    localparam int RTW   = NW / 2;
    localparam int CNTW  = $clog2(NW + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_A, ST_MUL_B, ST_LOAD_DIV, ST_DIV, ST_SQRT, ST_FIN, ST_DONE
    } t_state;

    // Record fields.
    logic [CW-1:0]          w_n;
    logic signed [SUMW-1:0] w_sum;
    logic [SQSW-1:0]        w_sq;
    logic signed [S-1:0]    w_min;
    logic signed [S-1:0]    w_max;
    t_tube_flags            w_flags;
    logic [SUMW-1:0]        w_smag;
    logic                   w_na;

    assign {w_n, w_sum, w_sq, w_min, w_max, w_flags} = i_rec;
    assign w_smag = w_sum[SUMW-1] ? SUMW'(-w_sum) : SUMW'(w_sum);
    assign w_na   = w_flags.length_overflow
                 || (w_flags.saw_missing && !i_cfg.drop_missing)
                 || (w_n == '0)
                 || (i_cfg.statistic > STAT_SUM);

    t_state                r_state;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_is_std;
    logic                  r_neg;
    logic [SUMW-1:0]       r_smag;
    logic [DW-1:0]         r_acc;
    logic [DW-1:0]         r_mcand;
    logic [SUMW-1:0]       r_mplier;
    logic [NW-1:0]         r_num;
    logic [DVW-1:0]        r_div;
    logic [DVW-1:0]        r_rem;
    logic [RTW-1:0]        r_root;
    logic [RTW:0]          r_srem;
    logic [RESULT_W-1:0]   r_res;
    logic                  r_res_na;
    logic                  r_out_valid;
    logic [RESULT_W-1:0]   r_out_value;
    logic                  r_out_na;

    // Divider and square root step logic.
    logic [DVW:0]          w_rem_t;
    logic                  w_q_bit;
    logic [RTW+2:0]        w_srem_t;
    logic [RTW+2:0]        w_trial;
    logic                  w_r_bit;
    logic [RESULT_W-1:0]   w_qmag;

    assign w_rem_t  = {r_rem, r_num[NW-1]};
    assign w_q_bit  = (w_rem_t >= {1'b0, r_div});
    assign w_srem_t = {r_srem, r_num[NW-1:NW-2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_r_bit  = (w_srem_t >= w_trial);
    assign w_qmag   = RESULT_W'(r_num);

    assign o_rec_pop = (r_state == ST_IDLE) && i_rec_valid;
    assign o_valid   = r_out_valid;
    assign o_value   = r_out_value;
    assign o_na      = r_out_na;

    // Sequencer with its datapath and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_rec_valid) begin
                        r_neg    <= w_sum[SUMW-1];
                        r_smag   <= w_smag;
                        r_res_na <= w_na;
                        r_is_std <= !w_na && (i_cfg.statistic == STAT_STDDEV)
                                 && (w_n != CW'(1));
                        if (w_na) begin
                            r_res    <= '0;
                            r_state  <= ST_DONE;
                        end else if (i_cfg.statistic == STAT_MAX) begin
                            r_res   <= RESULT_W'(w_max) << F;
                            r_state <= ST_DONE;
                        end else if (i_cfg.statistic == STAT_MIN) begin
                            r_res   <= RESULT_W'(w_min) << F;
                            r_state <= ST_DONE;
                        end else if (i_cfg.statistic == STAT_SUM) begin
                            r_res   <= RESULT_W'(w_sum) << F;
                            r_state <= ST_DONE;
                        end else if (i_cfg.statistic == STAT_MEAN) begin
                            r_num   <= (NW'(w_smag) << F) + NW'(w_n >> 1);
                            r_div   <= DVW'(w_n);
                            r_rem   <= '0;
                            r_cnt   <= CNTW'(NW);
                            r_state <= ST_DIV;
                        end else if (w_n == CW'(1)) begin
                            r_res   <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_acc    <= '0;
                            r_mcand  <= DW'(w_sq);
                            r_mplier <= SUMW'(w_n);
                            r_div    <= DVW'(w_n) * DVW'(w_n - 1'b1);
                            r_cnt    <= CNTW'(CW);
                            r_state  <= ST_MUL_A;
                        end
                    end
                end
                // Count times sum of squares, one multiplier bit a cycle.
                ST_MUL_A: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_mcand  <= DW'(r_smag);
                        r_mplier <= r_smag;
                        r_cnt    <= CNTW'(SUMW);
                        r_state  <= ST_MUL_B;
                    end else begin
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                // Subtract the squared sum, one bit a cycle.
                ST_MUL_B: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc - r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= ST_LOAD_DIV;
                    end
                end
                ST_LOAD_DIV: begin
                    r_num   <= NW'(r_acc) << (2 * F + 2);
                    r_rem   <= '0;
                    r_cnt   <= CNTW'(NW);
                    r_state <= ST_DIV;
                end
                // Restoring division, one quotient bit a cycle.
                ST_DIV: begin
                    r_rem <= w_q_bit ? DVW'(w_rem_t - {1'b0, r_div}) : DVW'(w_rem_t);
                    r_num <= {r_num[NW-2:0], w_q_bit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        if (r_is_std) begin
                            r_root  <= '0;
                            r_srem  <= '0;
                            r_cnt   <= CNTW'(RTW);
                            r_state <= ST_SQRT;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                // Digit-by-digit square root, one root bit a cycle.
                ST_SQRT: begin
                    r_srem <= w_r_bit ? (RTW+1)'(w_srem_t - w_trial) : (RTW+1)'(w_srem_t);
                    r_root <= {r_root[RTW-2:0], w_r_bit};
                    r_num  <= r_num << 2;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (r_is_std) begin
                        r_res <= RESULT_W'(((RTW+1)'(r_root) + 1'b1) >> 1);
                    end else begin
                        r_res <= r_neg ? -w_qmag : w_qmag;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res;
                        r_out_na    <= r_res_na;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // The division remainder always stays below the divisor.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    // The square root remainder never exceeds twice the partial root.
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> (r_srem <= {r_root, 1'b0}))
        else $error("square root remainder out of range");

    // An NA result always carries a zero value.
    a_na_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_na) |-> (r_out_value == '0))
        else $error("NA result with nonzero value");
`endif

endmodule

// File: hdl/tube_statistic_reducer_unit.sv
// Tube statistic reducer: one sample transfer per cycle while the record queue has room.
// Max, min, sum and NA results come straight from the record; mean goes through the
// divider, standard deviation through the multiplier, divider and square root. The
// back end is bit-serial; with two finished records waiting, full stalls the input.
// Synchronous active-low reset clears the tube accumulators, the queue fill state,
// the back end sequencer and output valid, and the configuration.
module tube_statistic_reducer_unit
    import tsr_pkg::*;
#(
    parameter int MAX_TUBE_LENGTH = 1024,
    parameter int SAMPLE_BITS     = 24,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [FIELD_W-1:0]    i_sample,
    input  logic                  i_last_in_tube,
    output logic                  empty,
    input  logic                  pop,
    output logic [RESULT_W-1:0]   o_result_value,
    output logic                  o_result_is_na,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [FIELD_W-1:0]    i_cfg_data
);

    localparam int CW    = $clog2(MAX_TUBE_LENGTH + 1);
    localparam int REC_W = CW + (SAMPLE_BITS + CW) + (2 * SAMPLE_BITS - 2 + CW)
                         + 2 * SAMPLE_BITS + 2;

    t_cfg             r_cfg;
    logic             w_accept;
    logic             w_rec_push;
    logic [REC_W-1:0] w_rec_in;
    logic [REC_W-1:0] w_rec_out;
    logic             w_rec_empty;
    logic             w_rec_pop;
    logic             w_out_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.statistic    <= STAT_MEAN;
            r_cfg.drop_missing <= 1'b0;
            r_cfg.missing_code <= MISSING_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STATISTIC:    r_cfg.statistic    <= i_cfg_data[STAT_W-1:0];
                CFG_DROP_MISSING: r_cfg.drop_missing <= i_cfg_data[0];
                CFG_MISSING_CODE: r_cfg.missing_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A sample transfer needs room for a finished tube record.
    assign w_accept = push && !full;

    tsr_front #(
        .MAX_TUBE_LENGTH (MAX_TUBE_LENGTH),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (w_accept),
        .i_sample       (i_sample),
        .i_last_in_tube (i_last_in_tube),
        .o_rec_push     (w_rec_push),
        .o_rec          (w_rec_in)
    );

    tsr_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_data  (w_rec_in),
        .o_full  (full),
        .i_pop   (w_rec_pop),
        .o_empty (w_rec_empty),
        .o_data  (w_rec_out)
    );

    tsr_back #(
        .MAX_TUBE_LENGTH (MAX_TUBE_LENGTH),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rec_valid (!w_rec_empty),
        .i_rec       (w_rec_out),
        .o_rec_pop   (w_rec_pop),
        .o_valid     (w_out_valid),
        .i_pop       (pop),
        .o_value     (o_result_value),
        .o_na        (o_result_is_na)
    );

    assign empty = !w_out_valid;

endmodule

// File: test/tube_statistic_reducer_unit_tb.sv
// Self-checking testbench for the tube statistic reducer unit.
// Depends on tsr_pkg and tube_statistic_reducer_unit, which needs the front, queue and back files.
module tube_statistic_reducer_unit_tb;
    import tsr_pkg::*;

    localparam int  TUBE_MAX        = 1024;
    localparam int  FRAC            = 16;
    localparam int  SETTLE_CYCLES   = 400;
    localparam int  CYCLE_LIMIT     = 5000000;
    localparam int  NUM_PHASES      = 10;
    localparam int  ITEMS_PER_PHASE = 80;
    localparam logic [STAT_W-1:0] STAT_UNUSED_LO = 3'd5;
    localparam logic [STAT_W-1:0] STAT_UNUSED_HI = 3'd7;
    localparam logic [FIELD_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [FIELD_W-1:0] SAMPLE_MIN = 24'h800000;

    typedef struct {
        logic [RESULT_W-1:0] value;
        logic                na;
    } t_tube_result;

    // Predicts one statistic per tube and checks the results in order.
    class tube_stat_scoreboard;
        t_tube_result expected_stats[$];
        logic [STAT_W-1:0]  statistic;
        logic               drop_missing;
        logic [FIELD_W-1:0] missing_code;
        longint             valid_n;
        longint             sum;
        logic [63:0]        square_sum;
        longint             min_seen;
        longint             max_seen;
        bit                 any_missing;
        bit                 too_long;
        int                 taken;
        int                 errors;
        int                 tubes_checked;
        int                 na_checked;

        function new();
            statistic = STAT_MEAN;
            drop_missing = 1'b0;
            missing_code = MISSING_RESET;
            errors = 0;
            tubes_checked = 0;
            na_checked = 0;
            clear_tube();
        endfunction

        function void clear_tube();
            valid_n = 0;
            sum = 0;
            square_sum = 0;
            min_seen = 64'sd8388607;
            max_seen = -64'sd8388608;
            any_missing = 0;
            too_long = 0;
            taken = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
            case (idx)
                CFG_STATISTIC:    statistic = data[STAT_W-1:0];
                CFG_DROP_MISSING: drop_missing = data[0];
                CFG_MISSING_CODE: missing_code = data;
                default: ;
            endcase
        endfunction

        // Standard deviation in fixed point, rounded to nearest.
        function logic [63:0] stddev_fixed();
            logic [127:0] dev;
            logic [127:0] scaled;
            logic [63:0]  root;
            logic [63:0]  trial;
            logic [63:0]  mag;
            mag = (sum < 0) ? 64'(-sum) : 64'(sum);
            dev = 128'(valid_n) * 128'(square_sum) - 128'(mag) * 128'(mag);
            scaled = (dev << (2 * FRAC + 2)) / 128'(valid_n * (valid_n - 1));
            root = 0;
            for (int b = 59; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (128'(trial) * 128'(trial) <= scaled)
                    root = trial;
            end
            return (root + 64'd1) / 64'd2;
        endfunction

        function void note_sample(logic [FIELD_W-1:0] sample, logic last);
            longint       x;
            longint       value;
            logic [63:0]  mag;
            bit           na;
            t_tube_result res;
            x = longint'($signed(sample));
            if (taken >= TUBE_MAX) begin
                too_long = 1;
            end else begin
                taken++;
                if (sample == missing_code) begin
                    any_missing = 1;
                end else begin
                    valid_n++;
                    sum += x;
                    square_sum += 64'(x * x);
                    if (x < min_seen) min_seen = x;
                    if (x > max_seen) max_seen = x;
                end
            end
            if (!last)
                return;
            na = too_long || (any_missing && !drop_missing) || valid_n == 0
                 || statistic > STAT_SUM;
            value = 0;
            if (!na) begin
                mag = (sum < 0) ? 64'(-sum) : 64'(sum);
                case (statistic)
                    STAT_MEAN: begin
                        value = longint'((mag * 64'd65536 + 64'(valid_n / 2)) / 64'(valid_n));
                        if (sum < 0) value = -value;
                    end
                    STAT_MAX:    value = max_seen * 65536;
                    STAT_MIN:    value = min_seen * 65536;
                    STAT_STDDEV: value = (valid_n > 1) ? longint'(stddev_fixed()) : 0;
                    default:     value = sum * 65536;
                endcase
            end
            res.value = na ? '0 : RESULT_W'(value);
            res.na = na;
            expected_stats.push_back(res);
            clear_tube();
        endfunction

        function void check_result(logic [RESULT_W-1:0] value, logic na);
            t_tube_result exp_res;
            if (expected_stats.size() == 0) begin
                $display("%0t: unexpected result value=%h na=%b", $time, value, na);
                errors++;
                return;
            end
            exp_res = expected_stats.pop_front();
            tubes_checked++;
            if (exp_res.na) na_checked++;
            if (value !== exp_res.value) begin
                $display("%0t: result_value expected %h actual %h",
                         $time, exp_res.value, value);
                errors++;
            end
            if (na !== exp_res.na) begin
                $display("%0t: result_is_na expected %b actual %b",
                         $time, exp_res.na, na);
                errors++;
            end
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [FIELD_W-1:0]   i_sample = '0;
    logic                 i_last_in_tube = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [RESULT_W-1:0]  o_result_value;
    logic                 o_result_is_na;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FIELD_W-1:0]   i_cfg_data = '0;

    tube_statistic_reducer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_sample(i_sample), .i_last_in_tube(i_last_in_tube),
        .empty(empty), .pop(pop), .o_result_value(o_result_value),
        .o_result_is_na(o_result_is_na),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    tube_stat_scoreboard sb = new();
    bit  no_idle = 0;
    bit  reset_done = 0;
    int  cycles = 0;
    int  samples_sent = 0;

    always #1 i_clk = ~i_clk;

    // Give up if the run stalls.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // Send one sample; returns after its transfer.
    task automatic send_sample(logic [FIELD_W-1:0] sample, logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_sample <= sample;
        i_last_in_tube <= last;
        do @(posedge i_clk); while (full);
        sb.note_sample(sample, last);
        samples_sent++;
    endtask

    // Settle all outstanding tubes, including back-end work still in flight.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [STAT_W-1:0] stat, logic drop, logic [FIELD_W-1:0] code);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_STATISTIC;
        i_cfg_data <= FIELD_W'(stat);
        @(posedge i_clk);
        i_cfg_index <= CFG_DROP_MISSING;
        i_cfg_data <= FIELD_W'(drop);
        @(posedge i_clk);
        i_cfg_index <= CFG_MISSING_CODE;
        i_cfg_data <= code;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(CFG_STATISTIC, FIELD_W'(stat));
        sb.set_reg(CFG_DROP_MISSING, FIELD_W'(drop));
        sb.set_reg(CFG_MISSING_CODE, code);
    endtask

    // Pick a sample that hits the missing code and the extremes now and then.
    function logic [FIELD_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return sb.missing_code;
        if (r < 15) return SAMPLE_MAX;
        if (r < 20) return SAMPLE_MIN;
        if (r < 60) return FIELD_W'($urandom);
        return FIELD_W'($signed($urandom_range(0, 2000)) - 1000);
    endfunction

    task automatic send_tube(int len);
        for (int k = 0; k < len; k++)
            send_sample(pick_sample(), k == len - 1);
    endtask

    // Result side: random stalls, then take the oldest result.
    initial begin
        int stall;
        wait (reset_done);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_result_value, o_result_is_na);
        end
    end

    initial begin
        logic [STAT_W-1:0]  phase_stat[NUM_PHASES];
        logic               phase_drop[NUM_PHASES];
        logic [FIELD_W-1:0] phase_code[NUM_PHASES];
        int                 sent;
        int                 len;

        phase_stat = '{STAT_MEAN, STAT_MAX, STAT_MIN, STAT_STDDEV, STAT_SUM,
                       STAT_STDDEV, STAT_UNUSED_HI, STAT_MEAN, STAT_STDDEV, STAT_UNUSED_LO};
        phase_drop = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        phase_code = '{SAMPLE_MIN, SAMPLE_MAX, 24'd0, FIELD_W'($urandom), FIELD_W'($urandom),
                       24'hFFFFFF, FIELD_W'($urandom), SAMPLE_MAX, SAMPLE_MIN, 24'd5};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reset_done = 1;

        // Directed tubes under the reset configuration (mean, missing gives NA).
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(24'h800001, 1'b1);
        send_sample(24'd3, 1'b0);
        send_sample(24'd4, 1'b1);
        send_sample(24'hFFFFFD, 1'b0);
        send_sample(24'hFFFFFC, 1'b1);
        drain();
        // Standard deviation with one sample, extremes, and all missing.
        write_config(STAT_STDDEV, 1'b1, 24'd7);
        send_sample(24'd9, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(24'd7, 1'b0);
        send_sample(24'd7, 1'b1);
        send_sample(24'd7, 1'b0);
        send_sample(24'd1, 1'b0);
        send_sample(24'd2, 1'b1);
        drain();

        // Random phases through every statistic code and register extreme.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_config(phase_stat[p], phase_drop[p], phase_code[p]);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                send_tube(len);
                sent += len;
                // Hold the sender until the result queue runs dry once per phase.
                if (sent >= ITEMS_PER_PHASE / 2 && sent - len < ITEMS_PER_PHASE / 2) begin
                    push <= 1'b0;
                    do @(posedge i_clk); while (sb.pending() != 0);
                end
            end
            drain();
        end
        no_idle = 0;

        drain();
        $display("Covered %0d samples and %0d tubes (%0d NA) across %0d settings.",
                 samples_sent, sb.tubes_checked, sb.na_checked, NUM_PHASES + 2);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/tsr_pkg.sv
hdl/tsr_front.sv
hdl/tsr_queue.sv
hdl/tsr_back.sv
hdl/tube_statistic_reducer_unit.sv
test/tube_statistic_reducer_unit_tb.sv
